// ----- hdl/rhpm_pkg.sv -----
package rhpm_pkg;

    localparam int PATTERN_MAX_DEFAULT = 32;

    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 5;
    localparam int LEN_W   = 6;
    localparam int HASH_W  = 30;
    localparam int RED_W   = HASH_W + 1;
    localparam int SUM_W   = HASH_W + 3;
    localparam int SEEN_W  = 33;
    localparam int INDEX_W = 32;

    localparam logic [63:0] HASH_MOD = 64'd1000000007;

    localparam logic [OP_W-1:0] OP_PATTERN = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
    localparam logic [OP_W-1:0] OP_END     = 2'd2;

    localparam logic RESULT_MATCH     = 1'b0;
    localparam logic RESULT_NOT_FOUND = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
    } item_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic store_we;
    } win_ctrl_t;

    // value of the top byte of a 38-bit word, i.e. i * 2^30 mod p
    typedef logic [HASH_W-1:0] fold_tab_t [256];

    function automatic fold_tab_t make_fold_table();
        fold_tab_t   t;
        logic [63:0] v;
        for (int i = 0; i < 256; i++) begin
            v = (64'(i) << HASH_W) % HASH_MOD;
            t[i] = HASH_W'(v);
        end
        return t;
    endfunction

    localparam fold_tab_t FOLD_TABLE = make_fold_table();

    // final reduction of a sum below five times the modulus
    function automatic logic [HASH_W-1:0] mod_reduce(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] m1;
        logic [SUM_W-1:0] m2;
        logic [SUM_W-1:0] m3;
        logic [SUM_W-1:0] m4;
        logic [SUM_W-1:0] r;
        m1 = SUM_W'(HASH_MOD);
        m2 = SUM_W'(HASH_MOD * 2);
        m3 = SUM_W'(HASH_MOD * 3);
        m4 = SUM_W'(HASH_MOD * 4);
        priority if (x >= m4) begin
            r = x - m4;
        end else if (x >= m3) begin
            r = x - m3;
        end else if (x >= m2) begin
            r = x - m2;
        end else if (x >= m1) begin
            r = x - m1;
        end else begin
            r = x;
        end
        return r[HASH_W-1:0];
    endfunction

endpackage

// ----- hdl/rhpm_window.sv -----
module rhpm_window #(
    parameter int PATTERN_MAX = rhpm_pkg::PATTERN_MAX_DEFAULT,
    parameter int NW = $clog2(PATTERN_MAX + 1),
    parameter int SW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rhpm_pkg::win_ctrl_t           ctrl,
    input  logic [NW-1:0]                 len,
    input  logic [rhpm_pkg::BYTE_W-1:0]   shift_byte,
    input  logic [rhpm_pkg::RED_W-1:0]    shift_red,
    input  logic [SW-1:0]                 store_index,
    input  logic [rhpm_pkg::BYTE_W-1:0]   store_byte,
    output logic [rhpm_pkg::RED_W-1:0]    outgoing_red,
    output logic                          bytes_equal
);

    // lane 0 holds the oldest byte, lane len-1 the newest
    logic [rhpm_pkg::BYTE_W-1:0] win_reg   [PATTERN_MAX];
    logic [rhpm_pkg::BYTE_W-1:0] win_next  [PATTERN_MAX];
    logic [rhpm_pkg::RED_W-1:0]  red_reg   [PATTERN_MAX];
    logic [rhpm_pkg::RED_W-1:0]  red_next  [PATTERN_MAX];
    logic [rhpm_pkg::BYTE_W-1:0] store_reg [PATTERN_MAX];

    always_comb begin
        for (int k = 0; k < PATTERN_MAX - 1; k++) begin
            if (NW'(k + 1) == len) begin
                win_next[k] = shift_byte;
                red_next[k] = shift_red;
            end else begin
                win_next[k] = win_reg[k + 1];
                red_next[k] = red_reg[k + 1];
            end
        end
        win_next[PATTERN_MAX - 1] = shift_byte;
        red_next[PATTERN_MAX - 1] = shift_red;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                win_reg[k] <= '0;
                red_reg[k] <= '0;
            end
        end else if (ctrl.shift) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                win_reg[k] <= win_next[k];
                red_reg[k] <= red_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.store_we) begin
            store_reg[store_index] <= store_byte;
        end
    end

    always_comb begin
        bytes_equal = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (NW'(j) < len && win_reg[j] != store_reg[j]) begin
                bytes_equal = 1'b0;
            end
        end
    end

    assign outgoing_red = red_reg[0];

endmodule

// ----- hdl/rolling_hash_pattern_matcher.sv -----
// channel   direction  ports                                           transfer when
// -------   ---------  ----------------------------------------------  -----------------
// config    in         cfg_write, cfg_pattern_length                   cfg_write high
// input     in         s_operation, s_data_byte, s_pattern_position    s_valid & s_ready
// result    out        m_result_kind, m_start_index                    m_valid & m_ready
//
// one item per cycle sustained while no result is stalled; a result passes from its input transfer
// through the pipe input, product, fold, execute and match stages and then the output register
// the hash loop closes through one fold table lookup, a three-way add and a reduction
// reset is synchronous on aresetn low and clears all control and text state
// a stalled result holds the output register; each stage behind it holds once it is full,
// and s_ready falls when every stage is full

module rolling_hash_pattern_matcher #(
    parameter int PATTERN_MAX = rhpm_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_write,
    input  logic [rhpm_pkg::LEN_W-1:0]     cfg_pattern_length,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rhpm_pkg::OP_W-1:0]      s_operation,
    input  logic [rhpm_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic [rhpm_pkg::POS_W-1:0]     s_pattern_position,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_result_kind,
    output logic [rhpm_pkg::INDEX_W-1:0]   m_start_index
);

    localparam int NW     = $clog2(PATTERN_MAX + 1);
    localparam int SW     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CW     = (NW > rhpm_pkg::LEN_W) ? NW : rhpm_pkg::LEN_W;
    localparam int HW     = rhpm_pkg::HASH_W;
    localparam int PROD_W = rhpm_pkg::HASH_W + rhpm_pkg::BYTE_W;

    // p - 256^k mod p, so that a byte times the entry is minus its weight
    typedef logic [HW-1:0] pow_tab_t [PATTERN_MAX + 1];

    function automatic pow_tab_t make_neg_pow();
        pow_tab_t    t;
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k <= PATTERN_MAX; k++) begin
            t[k] = HW'(rhpm_pkg::HASH_MOD - p);
            p = (p * 64'd256) % rhpm_pkg::HASH_MOD;
        end
        return t;
    endfunction

    localparam pow_tab_t NEG_POW = make_neg_pow();

    // configuration
    logic [NW-1:0] len_reg;
    logic [NW-1:0] len_next;
    logic [HW-1:0] npow_reg;
    logic [CW-1:0] len_ext;

    always_comb begin
        len_ext = CW'(cfg_pattern_length);
        priority if (len_ext == '0) begin
            len_next = NW'(1);
        end else if (len_ext > CW'(PATTERN_MAX)) begin
            len_next = NW'(PATTERN_MAX);
        end else begin
            len_next = NW'(len_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= NW'(1);
            npow_reg <= NEG_POW[1];
        end else if (cfg_write) begin
            len_reg  <= len_next;
            npow_reg <= NEG_POW[len_next];
        end
    end

    // pipe stages
    logic                        in_valid_reg;
    rhpm_pkg::item_t             in_item_reg;
    logic                        pr_valid_reg;
    rhpm_pkg::item_t             pr_item_reg;
    logic [PROD_W-1:0]           pr_prod_reg;
    logic                        ra_valid_reg;
    rhpm_pkg::item_t             ra_item_reg;
    logic [rhpm_pkg::RED_W-1:0]  ra_red_reg;
    logic                        ex_valid_reg;
    rhpm_pkg::item_t             ex_item_reg;
    logic [rhpm_pkg::RED_W-1:0]  ex_red_reg;
    logic                        mt_valid_reg;
    logic                        mt_end_reg;
    logic                        out_valid_reg;
    logic                        out_kind_reg;
    logic [rhpm_pkg::INDEX_W-1:0] out_index_reg;

    logic out_free;
    logic mt_free;
    logic ex_free;
    logic ra_free;
    logic pr_free;
    logic in_free;
    logic ex_fire;

    assign out_free = !out_valid_reg || m_ready;
    assign mt_free  = !mt_valid_reg || out_free;
    assign ex_free  = !ex_valid_reg || mt_free;
    assign ra_free  = !ra_valid_reg || ex_free;
    assign pr_free  = !pr_valid_reg || ra_free;
    assign in_free  = !in_valid_reg || pr_free;
    assign ex_fire  = ex_valid_reg && mt_free;
    assign s_ready  = in_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            pr_valid_reg <= 1'b0;
            ra_valid_reg <= 1'b0;
            ex_valid_reg <= 1'b0;
        end else begin
            if (in_free) begin
                in_valid_reg <= s_valid;
            end
            if (pr_free) begin
                pr_valid_reg <= in_valid_reg;
            end
            if (ra_free) begin
                ra_valid_reg <= pr_valid_reg;
            end
            if (ex_free) begin
                ex_valid_reg <= ra_valid_reg;
            end
        end
    end

    logic [rhpm_pkg::RED_W-1:0] fold_sum;

    assign fold_sum = rhpm_pkg::RED_W'(rhpm_pkg::FOLD_TABLE[pr_prod_reg[PROD_W-1:HW]])
                    + rhpm_pkg::RED_W'(pr_prod_reg[HW-1:0]);

    always_ff @(posedge aclk) begin
        if (in_free) begin
            in_item_reg.op   <= s_operation;
            in_item_reg.data <= s_data_byte;
            in_item_reg.pos  <= s_pattern_position;
        end
        if (pr_free) begin
            pr_item_reg <= in_item_reg;
            pr_prod_reg <= PROD_W'(in_item_reg.data) * PROD_W'(npow_reg);
        end
        if (ra_free) begin
            ra_item_reg <= pr_item_reg;
            ra_red_reg  <= fold_sum;
        end
        if (ex_free) begin
            ex_item_reg <= ra_item_reg;
            ex_red_reg  <= ra_red_reg;
        end
    end

    // text and pattern state
    logic [HW-1:0]              ph_reg;
    logic [HW-1:0]              ph_next;
    logic [HW-1:0]              wh_reg;
    logic [HW-1:0]              wh_next;
    logic [rhpm_pkg::SEEN_W-1:0] seen_reg;
    logic [rhpm_pkg::SEEN_W-1:0] seen_next;
    logic                       found_reg;
    logic                       found_next;

    logic                       is_pattern;
    logic                       is_text;
    logic                       is_end;
    logic                       pos_ok;
    logic                       clear_text;
    logic                       mt_match;
    logic                       not_found;
    logic                       bytes_equal;
    logic [rhpm_pkg::RED_W-1:0] outgoing_red;
    rhpm_pkg::win_ctrl_t        win_ctrl;
    logic [rhpm_pkg::SUM_W-1:0] ph_sum;
    logic [rhpm_pkg::SUM_W-1:0] wh_sum;

    assign is_pattern = ex_item_reg.op == rhpm_pkg::OP_PATTERN;
    assign is_text    = ex_item_reg.op == rhpm_pkg::OP_TEXT;
    assign is_end     = ex_item_reg.op == rhpm_pkg::OP_END;
    assign pos_ok     = 32'(ex_item_reg.pos) < PATTERN_MAX;
    assign clear_text = cfg_write
                     || (ex_fire && (is_end || (is_pattern && ex_item_reg.pos == '0)));

    assign win_ctrl.clear    = clear_text;
    assign win_ctrl.shift    = ex_fire && is_text;
    assign win_ctrl.store_we = ex_fire && is_pattern && pos_ok;

    rhpm_window #(
        .PATTERN_MAX (PATTERN_MAX),
        .NW          (NW),
        .SW          (SW)
    ) u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (win_ctrl),
        .len          (len_reg),
        .shift_byte   (ex_item_reg.data),
        .shift_red    (ex_red_reg),
        .store_index  (SW'(ex_item_reg.pos)),
        .store_byte   (ex_item_reg.data),
        .outgoing_red (outgoing_red),
        .bytes_equal  (bytes_equal)
    );

    assign ph_sum = rhpm_pkg::SUM_W'(rhpm_pkg::FOLD_TABLE[ph_reg[HW-1:HW-8]])
                  + rhpm_pkg::SUM_W'({ph_reg[HW-9:0], ex_item_reg.data});
    assign wh_sum = rhpm_pkg::SUM_W'(rhpm_pkg::FOLD_TABLE[wh_reg[HW-1:HW-8]])
                  + rhpm_pkg::SUM_W'({wh_reg[HW-9:0], ex_item_reg.data})
                  + rhpm_pkg::SUM_W'(outgoing_red);

    assign mt_match = mt_valid_reg && !mt_end_reg
                   && seen_reg >= rhpm_pkg::SEEN_W'(len_reg)
                   && wh_reg == ph_reg && bytes_equal;
    assign not_found = !(found_reg || mt_match);

    always_comb begin
        ph_next    = ph_reg;
        wh_next    = wh_reg;
        seen_next  = seen_reg;
        found_next = found_reg;
        if (mt_match && mt_free) begin
            found_next = 1'b1;
        end
        if (ex_fire && is_pattern && pos_ok) begin
            if (ex_item_reg.pos == '0) begin
                ph_next = HW'(ex_item_reg.data);
            end else begin
                ph_next = rhpm_pkg::mod_reduce(ph_sum);
            end
        end
        if (ex_fire && is_text) begin
            wh_next = rhpm_pkg::mod_reduce(wh_sum);
            if (seen_reg != '1) begin
                seen_next = seen_reg + 1'b1;
            end
        end
        if (clear_text) begin
            wh_next    = '0;
            seen_next  = '0;
            found_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg    <= '0;
            wh_reg    <= '0;
            seen_reg  <= '0;
            found_reg <= 1'b0;
        end else begin
            ph_reg    <= ph_next;
            wh_reg    <= wh_next;
            seen_reg  <= seen_next;
            found_reg <= found_next;
        end
    end

    // match stage and output register
    logic [rhpm_pkg::SEEN_W-1:0]  start_diff;
    logic [rhpm_pkg::INDEX_W-1:0] start_index;

    assign start_diff  = seen_reg - rhpm_pkg::SEEN_W'(len_reg);
    assign start_index = start_diff[rhpm_pkg::SEEN_W-1] ? '1
                                                        : start_diff[rhpm_pkg::INDEX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mt_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (mt_free) begin
                mt_valid_reg <= ex_fire && (is_text || (is_end && not_found));
            end
            if (out_free) begin
                out_valid_reg <= mt_valid_reg && (mt_end_reg || mt_match);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mt_free) begin
            mt_end_reg <= is_end;
        end
        if (out_free) begin
            if (mt_end_reg) begin
                out_kind_reg  <= rhpm_pkg::RESULT_NOT_FOUND;
                out_index_reg <= '0;
            end else begin
                out_kind_reg  <= rhpm_pkg::RESULT_MATCH;
                out_index_reg <= start_index;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_kind_reg;
    assign m_start_index = out_index_reg;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int unsigned      WINDOW_MAX     = 32;
    localparam longint unsigned  MODULUS        = 64'd1000000007;
    localparam longint unsigned  BASE           = 64'd256;
    localparam logic [rhpm_pkg::OP_W-1:0] OP_IGNORED = 2'd3;
    localparam int               SETTLE_CYCLES  = 12;
    localparam int               WATCHDOG_LIMIT = 400;
    localparam int unsigned      RANDOM_ITEMS   = 700;

    typedef struct {
        logic                         kind;
        logic [rhpm_pkg::INDEX_W-1:0] index;
    } match_result_t;

    class window_match_predictor;
        logic [rhpm_pkg::BYTE_W-1:0] pattern_store [WINDOW_MAX];
        logic [rhpm_pkg::BYTE_W-1:0] window_bytes [WINDOW_MAX];
        longint unsigned             pat_hash;
        longint unsigned             window_hash;
        longint unsigned             leading_power;
        logic [rhpm_pkg::SEEN_W-1:0] bytes_seen;
        bit                          found_flag;
        logic [rhpm_pkg::LEN_W-1:0]  length_reg;
        match_result_t               expected_results [$];
        int                          mismatches;

        function new();
            for (int i = 0; i < WINDOW_MAX; i++) begin
                pattern_store[i] = '0;
            end
            pat_hash      = 0;
            length_reg    = 1;
            leading_power = 1;
            mismatches    = 0;
            clear_text();
        endfunction

        function void clear_text();
            for (int i = 0; i < WINDOW_MAX; i++) begin
                window_bytes[i] = '0;
            end
            window_hash = 0;
            bytes_seen  = '0;
            found_flag  = 1'b0;
        endfunction

        function int unsigned window_len();
            if (length_reg == 0) begin
                return 1;
            end
            if (length_reg > WINDOW_MAX) begin
                return WINDOW_MAX;
            end
            return length_reg;
        endfunction

        function void write_length(logic [rhpm_pkg::LEN_W-1:0] value);
            int unsigned n;
            length_reg    = value;
            n             = window_len();
            leading_power = 1;
            for (int i = 1; i < n; i++) begin
                leading_power = (leading_power * BASE) % MODULUS;
            end
            clear_text();
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_item(logic [rhpm_pkg::OP_W-1:0] op,
                                logic [rhpm_pkg::BYTE_W-1:0] data,
                                logic [rhpm_pkg::POS_W-1:0] pos);
            int unsigned     n;
            longint unsigned outgoing;
            longint unsigned start;
            bit              same;
            match_result_t   r;
            n = window_len();
            case (op)
                rhpm_pkg::OP_PATTERN: begin
                    pattern_store[pos] = data;
                    if (pos == 0) begin
                        pat_hash = data;
                        clear_text();
                    end else begin
                        pat_hash = (pat_hash * BASE + data) % MODULUS;
                    end
                end
                rhpm_pkg::OP_TEXT: begin
                    if (bytes_seen >= n) begin
                        outgoing    = (longint'(window_bytes[n-1]) * leading_power) % MODULUS;
                        window_hash = (window_hash + MODULUS - outgoing) % MODULUS;
                    end
                    window_hash = (window_hash * BASE + data) % MODULUS;
                    for (int i = WINDOW_MAX - 1; i > 0; i--) begin
                        window_bytes[i] = window_bytes[i-1];
                    end
                    window_bytes[0] = data;
                    if (bytes_seen != '1) begin
                        bytes_seen = bytes_seen + 1'b1;
                    end
                    if (bytes_seen >= n && window_hash == pat_hash) begin
                        same = 1'b1;
                        for (int j = 0; j < n; j++) begin
                            if (window_bytes[n-1-j] != pattern_store[j]) begin
                                same = 1'b0;
                            end
                        end
                        if (same) begin
                            found_flag = 1'b1;
                            start = longint'(bytes_seen) - n;
                            if (start > 64'hFFFF_FFFF) begin
                                start = 64'hFFFF_FFFF;
                            end
                            r.kind  = rhpm_pkg::RESULT_MATCH;
                            r.index = start[rhpm_pkg::INDEX_W-1:0];
                            expected_results.push_back(r);
                        end
                    end
                end
                rhpm_pkg::OP_END: begin
                    if (!found_flag) begin
                        r.kind  = rhpm_pkg::RESULT_NOT_FOUND;
                        r.index = '0;
                        expected_results.push_back(r);
                    end
                    clear_text();
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic kind, logic [rhpm_pkg::INDEX_W-1:0] index);
            match_result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d index %0d",
                         $time, kind, index);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, kind);
                mismatches++;
            end
            if (index !== want.index) begin
                $display("%0t: start_index expected %0d actual %0d",
                         $time, want.index, index);
                mismatches++;
            end
        endfunction
    endclass

    logic                          aclk               = 1'b0;
    logic                          aresetn            = 1'b0;
    logic                          cfg_write          = 1'b0;
    logic [rhpm_pkg::LEN_W-1:0]    cfg_pattern_length = '0;
    logic                          s_valid            = 1'b0;
    logic                          s_ready;
    logic [rhpm_pkg::OP_W-1:0]     s_operation        = '0;
    logic [rhpm_pkg::BYTE_W-1:0]   s_data_byte        = '0;
    logic [rhpm_pkg::POS_W-1:0]    s_pattern_position = '0;
    logic                          m_valid;
    logic                          m_ready            = 1'b1;
    logic                          m_result_kind;
    logic [rhpm_pkg::INDEX_W-1:0]  m_start_index;

    window_match_predictor         predictor;
    bit                            idle_on        = 1'b1;
    int unsigned                   items_sent     = 0;
    int                            ready_stall    = 0;
    int                            stalled_cycles = 0;
    bit                            alpha_full     = 1'b1;
    logic [rhpm_pkg::BYTE_W-1:0]   alpha_base     = '0;

    rolling_hash_pattern_matcher #(
        .PATTERN_MAX(WINDOW_MAX)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_write          (cfg_write),
        .cfg_pattern_length (cfg_pattern_length),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_data_byte        (s_data_byte),
        .s_pattern_position (s_pattern_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_kind      (m_result_kind),
        .m_start_index      (m_start_index)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (ready_stall > 0) begin
            ready_stall--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_stall = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            predictor.check_result(m_result_kind, m_start_index);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_write) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, stalled_cycles);
                $display("rolling_hash_pattern_matcher regression: fail");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [rhpm_pkg::OP_W-1:0] op,
                             input logic [rhpm_pkg::BYTE_W-1:0] data,
                             input logic [rhpm_pkg::POS_W-1:0] pos);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_operation        <= op;
        s_data_byte        <= data;
        s_pattern_position <= pos;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predictor.note_item(op, data, pos);
        if (op != OP_IGNORED) begin
            items_sent++;
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (predictor.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_length(input logic [rhpm_pkg::LEN_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_pattern_length <= value;
        cfg_write          <= 1'b1;
        @(posedge aclk);
        predictor.write_length(value);
        @(negedge aclk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [rhpm_pkg::BYTE_W-1:0] pick_byte();
        if (alpha_full) begin
            return rhpm_pkg::BYTE_W'($urandom_range(0, 255));
        end
        return alpha_base + rhpm_pkg::BYTE_W'($urandom_range(0, 2));
    endfunction

    function automatic logic [rhpm_pkg::LEN_W-1:0] pick_length();
        case ($urandom_range(0, 19))
            0, 1: begin
                return 6'd32;
            end
            2: begin
                return 6'd63;
            end
            3: begin
                return 6'd0;
            end
            4: begin
                return 6'd1;
            end
            5, 6, 7: begin
                return rhpm_pkg::LEN_W'($urandom_range(7, 63));
            end
            default: begin
                return rhpm_pkg::LEN_W'($urandom_range(1, 6));
            end
        endcase
    endfunction

    task automatic run_phase(input logic [rhpm_pkg::LEN_W-1:0] len_value, input bit noisy);
        int unsigned                 n;
        int unsigned                 cnt;
        int unsigned                 text_len;
        int unsigned                 k;
        int unsigned                 cut;
        int unsigned                 tmp;
        int unsigned                 order [WINDOW_MAX+1];
        logic [rhpm_pkg::BYTE_W-1:0] pat [WINDOW_MAX+1];
        write_length(len_value);
        n          = (len_value == 0) ? 1 : ((len_value > WINDOW_MAX) ? WINDOW_MAX : len_value);
        alpha_full = ($urandom_range(0, 2) == 0);
        alpha_base = rhpm_pkg::BYTE_W'($urandom_range(0, 253));
        for (k = 0; k <= WINDOW_MAX; k++) begin
            order[k] = k;
            pat[k]   = pick_byte();
        end
        cnt = n;
        if (noisy && $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
                0: begin
                    if (cnt > 1) begin
                        cnt--;
                    end
                end
                1: begin
                    if (n > 1) begin
                        k            = $urandom_range(0, n - 2);
                        tmp          = order[k];
                        order[k]     = order[k+1];
                        order[k+1]   = tmp;
                    end
                end
                default: begin
                    if (n < WINDOW_MAX) begin
                        cnt++;
                    end
                end
            endcase
        end
        for (k = 0; k < cnt; k++) begin
            send_item(rhpm_pkg::OP_PATTERN, pat[order[k]], rhpm_pkg::POS_W'(order[k]));
        end
        if ($urandom_range(0, 5) == 0) begin
            drain_results();
        end
        text_len = $urandom_range(0, 3 * n + 12);
        k = 0;
        while (k < text_len) begin
            if (noisy && $urandom_range(0, 15) == 0) begin
                send_item(rhpm_pkg::OP_W'($urandom_range(0, 3)),
                          rhpm_pkg::BYTE_W'($urandom_range(0, 255)),
                          rhpm_pkg::POS_W'($urandom_range(0, 31)));
                k++;
            end else if (k + n <= text_len && $urandom_range(0, 3) == 0) begin
                cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : n;
                for (int j = 0; j < n; j++) begin
                    send_item(rhpm_pkg::OP_TEXT, (j == cut) ? (pat[j] ^ 8'h01) : pat[j],
                              rhpm_pkg::POS_W'($urandom_range(0, 31)));
                end
                k += n;
            end else begin
                send_item(rhpm_pkg::OP_TEXT, pick_byte(),
                          rhpm_pkg::POS_W'($urandom_range(0, 31)));
                k++;
            end
        end
        if ($urandom_range(0, 7) != 0) begin
            send_item(rhpm_pkg::OP_END, rhpm_pkg::BYTE_W'($urandom_range(0, 255)),
                      rhpm_pkg::POS_W'($urandom_range(0, 31)));
        end
    endtask

    initial begin
        int unsigned random_base;
        predictor = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // fill every pattern entry once
        for (int i = 0; i < WINDOW_MAX; i++) begin
            send_item(rhpm_pkg::OP_PATTERN, rhpm_pkg::BYTE_W'($urandom_range(0, 255)),
                      rhpm_pkg::POS_W'(i));
        end

        write_length(6'd2);
        send_item(rhpm_pkg::OP_PATTERN, 8'hFF, 5'd0);
        send_item(rhpm_pkg::OP_PATTERN, 8'h00, 5'd1);
        send_item(rhpm_pkg::OP_TEXT, 8'hFF, 5'd0);
        send_item(rhpm_pkg::OP_TEXT, 8'h00, 5'd31);
        send_item(rhpm_pkg::OP_TEXT, 8'hFF, 5'd0);
        send_item(rhpm_pkg::OP_TEXT, 8'h00, 5'd31);
        send_item(rhpm_pkg::OP_END, 8'h00, 5'd0);
        send_item(rhpm_pkg::OP_END, 8'hFF, 5'd31);
        // text shorter than the window
        send_item(rhpm_pkg::OP_TEXT, 8'hFF, 5'd0);
        send_item(rhpm_pkg::OP_END, 8'h00, 5'd0);
        send_item(OP_IGNORED, 8'h5A, 5'd31);

        // zero length acts as one
        write_length(6'd0);
        send_item(rhpm_pkg::OP_PATTERN, 8'hA5, 5'd0);
        send_item(rhpm_pkg::OP_TEXT, 8'hA5, 5'd0);
        send_item(rhpm_pkg::OP_TEXT, 8'h5A, 5'd0);
        send_item(rhpm_pkg::OP_TEXT, 8'hA5, 5'd0);
        // position zero restarts the text
        send_item(rhpm_pkg::OP_PATTERN, 8'hA5, 5'd0);
        send_item(rhpm_pkg::OP_TEXT, 8'hA5, 5'd0);
        send_item(rhpm_pkg::OP_END, 8'h00, 5'd0);

        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            if (items_sent - random_base > RANDOM_ITEMS - 120) begin
                idle_on = 1'b0;
            end else begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            run_phase(pick_length(), $urandom_range(0, 2) == 0);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (predictor.mismatches == 0 && predictor.pending() == 0) begin
            $display("rolling_hash_pattern_matcher regression: pass");
        end else begin
            $display("rolling_hash_pattern_matcher regression: fail");
        end
        $finish;
    end

endmodule
